// ----- rtl/sgdf_pkg.sv -----
// ----------------------------------------------------------------------------
// sgdf_pkg
// Shared constants, register codes and types of the depth outlier gate.
// ----------------------------------------------------------------------------
package sgdf_pkg;

    localparam int WINDOW_MAX_DEF  = 16;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int WLEN_W   = 5;
    localparam int FACTOR_W = 8;
    localparam int LIMIT_W  = 4;

    // factor is in 1/16 units, squared on both sides of the gate compare
    localparam int LHS_SHIFT = 8;

    localparam logic [WLEN_W-1:0]   WLEN_RST   = 5'd10;
    localparam logic [FACTOR_W-1:0] FACTOR_RST = 8'd32;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 4'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LENGTH    = 2'd0,
        REG_DEVIATION_FACTOR = 2'd1,
        REG_REJECT_LIMIT     = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [WLEN_W-1:0]   window_length;
        logic [FACTOR_W-1:0] deviation_factor;
        logic [LIMIT_W-1:0]  reject_limit;
    } t_cfg;

endpackage

// ----- rtl/sgdf_in_if.sv -----
// ----------------------------------------------------------------------------
// sgdf_in_if
// Sample channel: one depth word per handshake.
// ----------------------------------------------------------------------------
interface sgdf_in_if #(
    parameter int SAMPLE_BITS = sgdf_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] depth_sample;

    modport source (output valid, output depth_sample, input ready);
    modport sink   (input valid, input depth_sample, output ready);
endinterface

// ----- rtl/sgdf_out_if.sv -----
// ----------------------------------------------------------------------------
// sgdf_out_if
// Result channel: gate decision and reference depth per handshake.
// ----------------------------------------------------------------------------
interface sgdf_out_if #(
    parameter int SAMPLE_BITS = sgdf_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   accepted;
    logic [SAMPLE_BITS-1:0] reference_depth;
    logic                   recentered;
    logic                   ignored;

    modport source (
        output valid, output accepted, output reference_depth,
        output recentered, output ignored, input ready
    );
    modport sink (
        input valid, input accepted, input reference_depth,
        input recentered, input ignored, output ready
    );
endinterface

// ----- rtl/sgdf_cfg_if.sv -----
// ----------------------------------------------------------------------------
// sgdf_cfg_if
// Configuration write channel: register index and data per handshake.
// ----------------------------------------------------------------------------
interface sgdf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [sgdf_pkg::CFG_IDX_W-1:0]   index;
    logic [sgdf_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/sgdf_front.sv -----
// ----------------------------------------------------------------------------
// sgdf_front
// Input stage: registers each sample word and flags a zero depth.
// ----------------------------------------------------------------------------
module sgdf_front #(
    parameter int SAMPLE_BITS = sgdf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sgdf_in_if.sink              i_in,
    output logic                 o_valid,
    output logic [SAMPLE_BITS:0] o_entry,
    input  logic                 i_ready
);

    logic                   r_valid;
    logic                   r_zero;
    logic [SAMPLE_BITS-1:0] r_sample;

    assign i_in.ready = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_entry    = {r_zero, r_sample};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_sample <= i_in.depth_sample;
            r_zero   <= (i_in.depth_sample == '0);
        end
    end

endmodule

// ----- rtl/sgdf_queue.sv -----
// ----------------------------------------------------------------------------
// sgdf_queue
// Two-entry queue between the input stage and the gate engine.
// ----------------------------------------------------------------------------
module sgdf_queue #(
    parameter int DATA_W = sgdf_pkg::SAMPLE_BITS_DEF + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_ready,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data,
    input  logic              i_ready
);

    logic [DATA_W-1:0] r_data [2];
    logic              r_wr;
    logic              r_rd;
    logic [1:0]        r_cnt;
    logic              push;
    logic              pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_data[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_data[r_wr] <= i_data;
        end
    end

endmodule

// ----- rtl/sgdf_div.sv -----
// ----------------------------------------------------------------------------
// sgdf_div
// Restoring divider, one quotient bit per cycle, for the window mean.
// ----------------------------------------------------------------------------
module sgdf_div #(
    parameter int N_W = sgdf_pkg::SAMPLE_BITS_DEF + 4,
    parameter int D_W = 5
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_dividend,
    input  logic [D_W-1:0] i_divisor,
    output logic           o_done,
    output logic [N_W-1:0] o_quotient
);

    localparam int C_W = $clog2(N_W + 1);

    logic [D_W:0]   r_rem;
    logic [N_W-1:0] r_quo;
    logic [C_W-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [D_W:0]   rem_sh;
    logic           fit;

    assign rem_sh     = {r_rem[D_W-1:0], r_quo[N_W-1]};
    assign fit        = (rem_sh >= {1'b0, i_divisor});
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == C_W'(N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fit ? (rem_sh - {1'b0, i_divisor}) : rem_sh;
            r_quo <= {r_quo[N_W-2:0], fit};
        end
    end

endmodule

// ----- rtl/sgdf_back.sv -----
// ----------------------------------------------------------------------------
// sgdf_back
// Gate engine: window store, running sums, deviation test, recentering.
// ----------------------------------------------------------------------------
module sgdf_back #(
    parameter int WINDOW_MAX  = sgdf_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = sgdf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sgdf_pkg::t_cfg       i_cfg,
    input  logic                 i_valid,
    input  logic [SAMPLE_BITS:0] i_entry,
    output logic                 o_pop,
    sgdf_out_if.source           o_out
);

    localparam int L_W     = $clog2(WINDOW_MAX);
    localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
    localparam int PW      = CNT_W + 1;
    localparam int SUM_W   = SAMPLE_BITS + L_W;
    localparam int SQ_W    = 2 * SAMPLE_BITS + L_W;
    localparam int DSQ_W   = 2 * SAMPLE_BITS;
    localparam int ND_W    = SAMPLE_BITS + CNT_W;
    localparam int LHS_W   = 2 * ND_W;
    localparam int VAR_W   = CNT_W + SQ_W;
    localparam int LO_W    = VAR_W / 2;
    localparam int HI_W    = VAR_W - LO_W;
    localparam int KK_W    = 2 * sgdf_pkg::FACTOR_W;
    localparam int RHS_W   = KK_W + VAR_W + 1;
    localparam int LSH_W   = LHS_W + sgdf_pkg::LHS_SHIFT;
    localparam int CMP_W   = (LSH_W > RHS_W) ? LSH_W : RHS_W;
    localparam int RUN_W   = sgdf_pkg::LIMIT_W;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL1 = 8'b0000_0010,
        S_MUL2 = 8'b0000_0100,
        S_MUL3 = 8'b0000_1000,
        S_CMP  = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_PUSH = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state                 r_state;
    logic [CNT_W-1:0]       r_count;
    logic [L_W-1:0]         r_slot;
    logic [SUM_W-1:0]       r_sum;
    logic [SQ_W-1:0]        r_sq;
    logic [SAMPLE_BITS-1:0] r_ref;
    logic [RUN_W-1:0]       r_run;
    logic                   r_out_valid;

    logic [SAMPLE_BITS-1:0] r_win [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] r_old;
    logic [SAMPLE_BITS-1:0] r_d;
    logic                   r_ign;
    logic                   r_acc;
    logic                   r_rec;
    logic [SAMPLE_BITS-1:0] r_diff;
    logic [ND_W-1:0]        r_ndiff;
    logic [2*SUM_W-1:0]     r_ssq;
    logic [KK_W-1:0]        r_kk;
    logic [VAR_W-1:0]       r_nsq;
    logic [DSQ_W-1:0]       r_dsq;
    logic [DSQ_W-1:0]       r_oldsq;
    logic [LHS_W-1:0]       r_lhs;
    logic [VAR_W-1:0]       r_var;
    logic [KK_W+HI_W-1:0]   r_rhs_hi;
    logic [KK_W+LO_W-1:0]   r_rhs_lo;

    logic                   r_out_acc;
    logic [SAMPLE_BITS-1:0] r_out_ref;
    logic                   r_out_rec;
    logic                   r_out_ign;

    logic [CNT_W-1:0]       eff_len;
    logic                   evict;
    logic [PW-1:0]          old_sum;
    logic [L_W-1:0]         old_idx;
    logic [L_W-1:0]         slot_next;
    logic [SAMPLE_BITS-1:0] in_d;
    logic [SAMPLE_BITS-1:0] in_diff;
    logic [RHS_W-1:0]       rhs;
    logic [CMP_W-1:0]       lhs_full;
    logic                   pass;
    logic [RUN_W:0]         run_next;
    logic                   recenter;
    logic                   out_load;
    logic                   div_start;
    logic                   div_done;
    logic [SUM_W-1:0]       div_quo;

    always_comb begin
        if (i_cfg.window_length == '0) begin
            eff_len = CNT_W'(1);
        end else if (32'(i_cfg.window_length) > WINDOW_MAX) begin
            eff_len = CNT_W'(WINDOW_MAX);
        end else begin
            eff_len = CNT_W'(i_cfg.window_length);
        end
    end

    assign evict     = (r_count >= eff_len) && (r_count != '0);
    assign old_sum   = PW'(r_slot) + PW'(WINDOW_MAX) - PW'(r_count);
    assign old_idx   = (old_sum >= PW'(WINDOW_MAX)) ? L_W'(old_sum - PW'(WINDOW_MAX))
                                                    : L_W'(old_sum);
    assign slot_next = (r_slot == L_W'(WINDOW_MAX - 1)) ? '0 : r_slot + 1'b1;

    assign in_d    = i_entry[SAMPLE_BITS-1:0];
    assign in_diff = (in_d >= r_ref) ? (in_d - r_ref) : (r_ref - in_d);

    assign rhs      = (RHS_W'(r_rhs_hi) << LO_W) + RHS_W'(r_rhs_lo);
    assign lhs_full = CMP_W'(r_lhs) << sgdf_pkg::LHS_SHIFT;
    assign pass     = (lhs_full <= CMP_W'(rhs));
    assign run_next = {1'b0, r_run} + 1'b1;
    assign recenter = (run_next > {1'b0, i_cfg.reject_limit});

    assign o_pop     = (r_state == S_IDLE) && i_valid;
    assign out_load  = (r_state == S_DONE) && (!r_out_valid || o_out.ready);
    assign div_start = (r_state == S_CMP) && !pass && recenter;

    sgdf_div #(
        .N_W (SUM_W),
        .D_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_slot      <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_ref       <= '0;
            r_run       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= i_entry[SAMPLE_BITS] ? S_DONE : S_MUL1;
                    end
                end
                S_MUL1: begin
                    if (r_count < CNT_W'(2)) begin
                        r_ref   <= r_d;
                        r_state <= S_PUSH;
                    end else begin
                        r_state <= S_MUL2;
                    end
                end
                S_MUL2: r_state <= S_MUL3;
                S_MUL3: r_state <= S_CMP;
                S_CMP: begin
                    if (pass) begin
                        r_ref   <= r_d;
                        r_run   <= '0;
                        r_state <= S_PUSH;
                    end else if (recenter) begin
                        r_state <= S_DIV;
                    end else begin
                        r_run   <= run_next[RUN_W-1:0];
                        r_state <= S_PUSH;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_ref   <= div_quo[SAMPLE_BITS-1:0];
                        r_run   <= '0;
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    r_sum   <= r_sum - (evict ? SUM_W'(r_old) : '0) + SUM_W'(r_d);
                    r_sq    <= r_sq - (evict ? SQ_W'(r_oldsq) : '0) + SQ_W'(r_dsq);
                    r_count <= evict ? r_count : r_count + 1'b1;
                    r_slot  <= slot_next;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSH) begin
            r_win[r_slot] <= r_d;
        end
        if (o_pop) begin
            r_old <= r_win[old_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_d    <= in_d;
                    r_ign  <= i_entry[SAMPLE_BITS];
                    r_diff <= in_diff;
                    r_acc  <= 1'b0;
                    r_rec  <= 1'b0;
                end
            end
            S_MUL1: begin
                r_ndiff <= ND_W'(r_count) * ND_W'(r_diff);
                r_ssq   <= r_sum * r_sum;
                r_kk    <= i_cfg.deviation_factor * i_cfg.deviation_factor;
                r_nsq   <= r_count * r_sq;
                r_dsq   <= r_d * r_d;
                r_oldsq <= r_old * r_old;
            end
            S_MUL2: begin
                r_lhs <= r_ndiff * r_ndiff;
                r_var <= (r_nsq >= VAR_W'(r_ssq)) ? (r_nsq - VAR_W'(r_ssq)) : '0;
            end
            S_MUL3: begin
                r_rhs_hi <= r_kk * r_var[VAR_W-1:LO_W];
                r_rhs_lo <= r_kk * r_var[LO_W-1:0];
            end
            S_CMP: begin
                r_acc <= pass;
            end
            S_DIV: begin
                if (div_done) begin
                    r_rec <= 1'b1;
                end
            end
            S_PUSH, S_DONE: begin
                r_acc <= r_acc;
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_acc <= r_acc;
            r_out_ref <= r_ref;
            r_out_rec <= r_rec;
            r_out_ign <= r_ign;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.accepted        = r_out_acc;
    assign o_out.reference_depth = r_out_ref;
    assign o_out.recentered      = r_out_rec;
    assign o_out.ignored         = r_out_ign;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(WINDOW_MAX))
        else $error("window count above capacity");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("quotient returned outside mean wait");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_acc && r_out_rec) && !(r_out_ign && (r_out_acc || r_out_rec)))
        else $error("conflicting result flags");

    a_push_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) |=> (r_count != '0) && (r_state == S_DONE))
        else $error("push left empty window");
`endif

endmodule

// ----- rtl/stdev_gate_depth_filter_unit.sv -----
// ----------------------------------------------------------------------------
// stdev_gate_depth_filter_unit
// Sliding-window deviation gate for depth samples in centimeters.
// i_in carries one depth word per handshake; zero depths are flagged ignored.
// o_out returns one result word per sample: accepted, reference depth,
// recentered and ignored flags, in input order.
// i_cfg writes window length, deviation factor and reject limit; write only
// while no sample is in flight. i_cfg.ready is always high.
// Per sample: ignored words skip the window, short windows set the reference
// and push, gated samples multiply, compare and push; a recenter adds a
// window-mean divide of one quotient bit per cycle. One sample is in the gate
// engine at a time; a two-entry queue and an input register take new words
// meanwhile. The multiply sequence and the serial divider set the rate.
// Reset clears counts, sums, reference and reject run; the window store has
// no clear; only its written entries are used. A stalled o_out holds its
// word; the engine finishes the next sample and waits to hand it over.
// ----------------------------------------------------------------------------
module stdev_gate_depth_filter_unit #(
    parameter int WINDOW_MAX  = sgdf_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = sgdf_pkg::SAMPLE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sgdf_in_if.sink    i_in,
    sgdf_out_if.source o_out,
    sgdf_cfg_if.sink   i_cfg
);

    sgdf_pkg::t_cfg       r_cfg;
    logic                 fr_valid;
    logic [SAMPLE_BITS:0] fr_entry;
    logic                 q_ready;
    logic                 q_valid;
    logic [SAMPLE_BITS:0] q_entry;
    logic                 bk_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_length    <= sgdf_pkg::WLEN_RST;
            r_cfg.deviation_factor <= sgdf_pkg::FACTOR_RST;
            r_cfg.reject_limit     <= sgdf_pkg::LIMIT_RST;
        end else if (i_cfg.valid) begin
            unique case (sgdf_pkg::t_reg_idx'(i_cfg.index))
                sgdf_pkg::REG_WINDOW_LENGTH: begin
                    r_cfg.window_length <= i_cfg.data[sgdf_pkg::WLEN_W-1:0];
                end
                sgdf_pkg::REG_DEVIATION_FACTOR: begin
                    r_cfg.deviation_factor <= i_cfg.data[sgdf_pkg::FACTOR_W-1:0];
                end
                sgdf_pkg::REG_REJECT_LIMIT: begin
                    r_cfg.reject_limit <= i_cfg.data[sgdf_pkg::LIMIT_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    sgdf_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (fr_valid),
        .o_entry (fr_entry),
        .i_ready (q_ready)
    );

    sgdf_queue #(
        .DATA_W (SAMPLE_BITS + 1)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .i_data  (fr_entry),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_entry),
        .i_ready (bk_pop)
    );

    sgdf_back #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .i_entry (q_entry),
        .o_pop   (bk_pop),
        .o_out   (o_out)
    );

endmodule
